FILE: design/pl_pkg.sv
// package for the positional list engine: sizes, codes, item types and helpers
package pl_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int OCNT_W = 6;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } pl_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } pl_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } pl_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } pl_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [OCNT_W-1:0]        item_count;
    logic                     has_value;
    logic signed [WORD_W-1:0] entry_value;
    logic                     last;
  } pl_out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic step;
  } pl_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic dump_more;
    logic step_last;
  } pl_sts_t;

  function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [WORD_W-1:0] w);
    return DATA_WIDTH'(w);
  endfunction

  function automatic logic signed [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(d);
    return WORD_W'(s);
  endfunction

endpackage

FILE: design/pl_ctrl.sv
// controller state machine: item acceptance and dump sequencing
module pl_ctrl import pl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  pl_sts_t sts_i,
  output pl_ctl_t ctl_o
);

  pl_state_e state_q, state_d;
  logic      accept;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.dump_more) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free && sts_i.step_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    ctl_o.exec    = 1'b0;
    ctl_o.step    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        ctl_o.exec = in_valid_i && sts_i.out_free;
      end
      S_DUMP: begin
        ctl_o.step = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/pl_datapath.sv
// datapath: shifting list cells, count, dump index and result register
module pl_datapath import pl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pl_ctl_t ctl_i,
  output pl_sts_t sts_o,
  input  pl_in_t  in_item_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output pl_out_t out_item_o
);

  logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  pl_out_t               out_q, out_d;

  logic [CMP_W-1:0]      count_w, pos_w, ins_pos, del_pos;
  logic                  is_ins, is_del, is_dump;
  logic                  ins_ok, del_ok;
  logic                  count_zero, count_full;
  pl_status_e            status;
  logic [DATA_WIDTH-1:0] new_data;

  assign count_w    = CMP_W'(count_q);
  assign pos_w      = CMP_W'(in_item_i.position);
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CNT_W'(CAPACITY));
  assign new_data   = to_data(in_item_i.value);

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_dump = 1'b0;
    ins_pos = '0;
    del_pos = '0;
    case (in_item_i.command)
      CMD_INS_FRONT: is_ins = 1'b1;
      CMD_INS_BACK: begin
        is_ins  = 1'b1;
        ins_pos = count_w;
      end
      CMD_INS_AT: begin
        is_ins  = 1'b1;
        ins_pos = pos_w;
      end
      CMD_DEL_FRONT: is_del = 1'b1;
      CMD_DEL_BACK: begin
        is_del  = 1'b1;
        del_pos = count_w - CMP_W'(1);
      end
      CMD_DEL_AT: begin
        is_del  = 1'b1;
        del_pos = pos_w;
      end
      CMD_DUMP: is_dump = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    status = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    if (is_ins) begin
      if (ins_pos > count_w) begin
        status = ST_BADPOS;
      end else if (count_full) begin
        status = ST_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end
    if (is_del) begin
      if (count_zero) begin
        status = ST_EMPTY;
      end else if (del_pos >= count_w) begin
        status = ST_BADPOS;
      end else begin
        del_ok = 1'b1;
      end
    end
  end

  // every cell chooses between its neighbors, the new word or itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ctl_i.exec && ins_ok) begin
        if (CMP_W'(i) == ins_pos) begin
          cells_q[i] <= new_data;
        end else if (CMP_W'(i) > ins_pos) begin
          if (i > 0) begin
            cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (ctl_i.exec && del_ok) begin
        if ((CMP_W'(i) >= del_pos) && (i < CAPACITY - 1)) begin
          cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.exec && ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.exec && del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.exec) begin
      idx_d = IDX_W'(1);
    end else if (ctl_i.step) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.dump_more = is_dump && (count_q > CNT_W'(1));
  assign sts_o.step_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctl_i.exec) begin
      out_valid_d         = 1'b1;
      out_d.status        = status;
      out_d.item_count    = OCNT_W'(count_d);
      out_d.has_value     = 1'b0;
      out_d.entry_value   = '0;
      out_d.last          = 1'b1;
      if (is_dump && !count_zero) begin
        out_d.has_value   = 1'b1;
        out_d.entry_value = to_word(cells_q[0]);
        out_d.last        = (count_q == CNT_W'(1));
      end
    end else if (ctl_i.step) begin
      out_valid_d       = 1'b1;
      out_d.status      = ST_OK;
      out_d.item_count  = OCNT_W'(count_q);
      out_d.has_value   = 1'b1;
      out_d.entry_value = to_word(cells_q[idx_q]);
      out_d.last        = sts_o.step_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/positional_list_engine_top.sv
// top level of the positional list engine
//
// Keeps an ordered list of up to CAPACITY signed words. Each input item is a
// command: insert at front, back or position, delete at front, back or
// position, or dump. Both channels use valid and stall; an item moves at a
// clock edge with valid high and stall low.
// Insert and delete shift all list cells in parallel and give one result
// item, registered: it appears the cycle after acceptance, and a new item
// can be taken every cycle while results keep draining.
// A dump gives one result item per entry (one for an empty list), one per
// cycle from the cell array read port while the receiver does not stall;
// the final one marked last. No new item is taken until it is registered.
// When the receiver stalls, the result register holds and the input side
// stalls too. Reset empties the list and clears the result valid flag; no
// clearing pass is needed since only entries below the count are read.
module positional_list_engine_top import pl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  pl_in_t  in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output pl_out_t out_item_o
);

  pl_ctl_t ctl;
  pl_sts_t sts;

  pl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: design/pl_checker.sv
// port level checker for the positional list engine and its bind
module pl_checker import pl_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input pl_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> in_stall_o)
    else $error("item accepted during a dump");

  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.has_value |-> out_item_o.status == ST_OK)
    else $error("dumped entry with bad status");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_value |-> out_item_o.entry_value == '0)
    else $error("entry value set without an entry");

endmodule

bind positional_list_engine_top pl_checker u_pl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

FILE: tb/sv/positional_list_engine_top_tb.sv
// testbench for the positional list engine: command items checked against a list model
module positional_list_engine_top_tb;
  import pl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid;
  logic    in_stall;
  pl_in_t  in_item;
  logic    out_valid;
  logic    out_stall;
  pl_out_t out_item;

  logic signed [DATA_WIDTH-1:0] list_model[$];
  pl_out_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  positional_list_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pl_status_e insert_entry(input int pos,
                                              input logic signed [WORD_W-1:0] v);
    if (pos > list_model.size()) return ST_BADPOS;
    if (list_model.size() >= CAPACITY) return ST_FULL;
    list_model.insert(pos, DATA_WIDTH'(v));
    return ST_OK;
  endfunction

  function automatic pl_status_e delete_entry(input int pos);
    if (list_model.size() == 0) return ST_EMPTY;
    if (pos >= list_model.size()) return ST_BADPOS;
    list_model.delete(pos);
    return ST_OK;
  endfunction

  function automatic void predict_list_op(input pl_in_t it);
    pl_out_t    r;
    pl_status_e st;
    int         n;
    n  = list_model.size();
    st = ST_OK;
    r  = '0;
    case (it.command)
      CMD_INS_FRONT: st = insert_entry(0, it.value);
      CMD_INS_BACK:  st = insert_entry(n, it.value);
      CMD_INS_AT:    st = insert_entry(int'(it.position), it.value);
      CMD_DEL_FRONT: st = delete_entry(0);
      CMD_DEL_BACK:  st = (n == 0) ? ST_EMPTY : delete_entry(n - 1);
      CMD_DEL_AT:    st = delete_entry(int'(it.position));
      CMD_DUMP: begin
        r.status     = ST_OK;
        r.item_count = OCNT_W'(n);
        if (n == 0) begin
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.has_value   = 1'b1;
            r.entry_value = WORD_W'(list_model[i]);
            r.last        = (i == n - 1);
            pending_results.push_back(r);
          end
        end
        return;
      end
      default: st = ST_OK;
    endcase
    r.status     = st;
    r.item_count = OCNT_W'(list_model.size());
    r.last       = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic pl_in_t make_item(input logic [CMD_W-1:0] cmd,
                                       input logic [POS_W-1:0] pos,
                                       input logic signed [WORD_W-1:0] v);
    pl_in_t it;
    it.command  = cmd;
    it.position = pos;
    it.value    = v;
    return it;
  endfunction

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert_cmd();
    case ($urandom_range(2))
      0:       return CMD_INS_FRONT;
      1:       return CMD_INS_BACK;
      default: return CMD_INS_AT;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_delete_cmd();
    case ($urandom_range(2))
      0:       return CMD_DEL_FRONT;
      1:       return CMD_DEL_BACK;
      default: return CMD_DEL_AT;
    endcase
  endfunction

  function automatic pl_in_t random_list_op(input int insert_pct);
    logic [CMD_W-1:0] cmd;
    int n;
    int r;
    int pos;
    n   = list_model.size();
    r   = $urandom_range(99);
    pos = $urandom_range(63);
    if (r < 5) begin
      cmd = CMD_DUMP;
    end else if (r < 7) begin
      cmd = CMD_UNUSED;
    end else if (r < 7 + insert_pct) begin
      cmd = pick_insert_cmd();
      if ($urandom_range(9) != 0) pos = $urandom_range(n);
    end else begin
      cmd = pick_delete_cmd();
      if (n > 0 && $urandom_range(9) != 0) pos = $urandom_range(n - 1);
    end
    return make_item(cmd, POS_W'(pos), random_word());
  endfunction

  task automatic send_item(input pl_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_list_op(it);
  endtask

  task automatic check_result(input pl_out_t got);
    pl_out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, got st=%0d cnt=%0d hv=%0b val=%h last=%0b",
               $time, got.status, got.item_count, got.has_value, got.entry_value, got.last);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: result mismatch: expected st=%0d cnt=%0d hv=%0b val=%h last=%0b",
                 $time, want.status, want.item_count, want.has_value, want.entry_value,
                 want.last);
        $display("%0t:                  actual   st=%0d cnt=%0d hv=%0b val=%h last=%0b",
                 $time, got.status, got.item_count, got.has_value, got.entry_value, got.last);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) check_result(out_item);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic test_directed();
    send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_FRONT, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_BACK, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd63, 32'sd0));
    send_item(make_item(CMD_INS_BACK, 6'd0, 32'sh7fff_ffff));
    send_item(make_item(CMD_INS_FRONT, 6'd0, 32'sh8000_0000));
    send_item(make_item(CMD_INS_AT, 6'd1, 32'sd0));
    send_item(make_item(CMD_INS_AT, 6'd3, -32'sd1));
    send_item(make_item(CMD_INS_AT, 6'd5, 32'sd5));
    send_item(make_item(CMD_INS_AT, 6'd63, 32'sd6));
    send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd4, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd63, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd1, 32'sd0));
    send_item(make_item(CMD_UNUSED, 6'd63, -32'sd1));
    send_item(make_item(CMD_DEL_BACK, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_FRONT, 6'd0, 32'sd0));
    send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_FRONT, 6'd0, 32'sd0));
    send_item(make_item(CMD_INS_AT, 6'd0, 32'sd1));
    send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_AT, 6'd0, 32'sd0));
  endtask

  task automatic test_fill_and_drain();
    while (list_model.size() < CAPACITY)
      send_item(make_item(pick_insert_cmd(), POS_W'($urandom_range(list_model.size())),
                          random_word()));
    send_item(make_item(CMD_INS_FRONT, 6'd0, random_word()));
    send_item(make_item(CMD_INS_BACK, 6'd0, random_word()));
    send_item(make_item(CMD_INS_AT, POS_W'(CAPACITY), random_word()));
    send_item(make_item(CMD_INS_AT, POS_W'(CAPACITY + 1), random_word()));
    send_item(make_item(CMD_INS_AT, 6'd63, random_word()));
    send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
    send_item(make_item(CMD_DEL_AT, POS_W'(CAPACITY), 32'sd0));
    while (list_model.size() > 0)
      send_item(make_item(pick_delete_cmd(), POS_W'($urandom_range(list_model.size() - 1)),
                          random_word()));
    send_item(make_item(CMD_DEL_BACK, 6'd0, 32'sd0));
  endtask

  task automatic test_random_mix(input int num_items);
    for (int k = 0; k < num_items; k++)
      send_item(random_list_op(((k / 30) % 2 == 0) ? 65 : 28));
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 40; k++) begin
      if (k == 20) send_item(make_item(CMD_DUMP, 6'd0, 32'sd0));
      else send_item(random_list_op(70));
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 62;
    test_directed();
    test_fill_and_drain();
    test_random_mix(40);

    send_idle_pct = 62;
    recv_idle_pct = 22;
    test_random_mix(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(40);
    test_backpressure();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
